// ===== hw/rtl/one_wire_rom_search_defines.svh =====
// Assertion helpers for the ROM search block.
`ifndef ONE_WIRE_ROM_SEARCH_DEFINES_SVH
`define ONE_WIRE_ROM_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define OWRS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("owrs check failed");

// Next-cycle implication.
`define OWRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("owrs check failed");

`endif

// ===== hw/rtl/owrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owrs_pkg;

  localparam int unsigned RomW  = 64;
  localparam int unsigned PosW  = 7;
  localparam int unsigned CrcW  = 8;
  localparam int unsigned CmdW  = 8;
  localparam int unsigned BitIdxW = $clog2(RomW);

  localparam logic [CrcW-1:0] CrcPoly      = 8'h8C;
  localparam logic [CmdW-1:0] SearchCmdRst = 8'hF0;
  localparam logic [CmdW-1:0] AlarmCmdRst  = 8'hEC;
  localparam logic [PosW-1:0] FirstPos     = 7'd1;
  localparam logic [PosW-1:0] LastPos      = 7'd64;

  localparam logic CfgSearchCmd = 1'b0;
  localparam logic CfgAlarmCmd  = 1'b1;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OpStart    = 2'd0,
    OpPresence = 2'd1,
    OpPair     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ActReset     = 3'd0,
    ActCommand   = 3'd1,
    ActReadPair  = 3'd2,
    ActWriteBit  = 3'd3,
    ActDone      = 3'd4
  } action_e;

  typedef struct packed {
    logic            two;
    action_e         act0;
    action_e         act1;
    logic [CmdW-1:0] cmd;
    logic            dir;
    logic            found;
    logic [RomW-1:0] rom;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/owrs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owrs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            op_i,
  input  logic                  find_first_i,
  input  logic                  do_reset_i,
  input  logic                  alarm_only_i,
  input  logic                  presence_i,
  input  logic [1:0]            bit_pair_i,
  input  logic                  full_i,
  output logic                  push_o,
  output owrs_pkg::job_t        job_o
);
  import owrs_pkg::*;

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhPresence = 2'd1,
    PhPair     = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [RomW-1:0] rom_q, rom_d;
  logic [PosW-1:0] ld_q, ld_d;
  logic            ldf_q, ldf_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] mark_q, mark_d;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [CmdW-1:0] chosen_q, chosen_d;
  logic [CmdW-1:0] scmd_q, acmd_q;

  logic                accept;
  logic [PosW-1:0]     pos_c;
  logic [BitIdxW-1:0]  bit_idx;
  logic                dir;
  logic [CrcW-1:0]     crc_n;
  logic                crc_ok;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    pos_c = pos_q;
    if ((pos_q < FirstPos) || (pos_q > LastPos)) begin
      pos_c = LastPos;
    end
    bit_idx = BitIdxW'(pos_c - FirstPos);
    if (bit_pair_i != 2'b00) begin
      dir = bit_pair_i[1];
    end else if (pos_c < ld_q) begin
      dir = rom_q[bit_idx];
    end else begin
      dir = (pos_c == ld_q);
    end
    crc_n  = (crc_q >> 1) ^ ((crc_q[0] ^ dir) ? CrcPoly : '0);
    crc_ok = (crc_n == '0);
  end

  always_comb begin
    rom_d    = rom_q;
    ld_d     = ld_q;
    ldf_d    = ldf_q;
    pos_d    = pos_q;
    mark_d   = mark_q;
    crc_d    = crc_q;
    phase_d  = phase_q;
    chosen_d = chosen_q;
    push_o   = 1'b0;
    job_o.two   = 1'b0;
    job_o.act0  = ActDone;
    job_o.act1  = ActDone;
    job_o.cmd   = '0;
    job_o.dir   = 1'b0;
    job_o.found = 1'b0;
    if (accept) begin
      unique case (op_e'(op_i))
        OpStart: begin
          if (find_first_i) begin
            ld_d  = '0;
            ldf_d = 1'b0;
            rom_d = '0;
          end
          phase_d = PhIdle;
          if (ldf_d) begin
            ld_d   = '0;
            ldf_d  = 1'b0;
            push_o = 1'b1;
          end else begin
            chosen_d = alarm_only_i ? acmd_q : scmd_q;
            push_o   = 1'b1;
            if (do_reset_i) begin
              phase_d    = PhPresence;
              job_o.act0 = ActReset;
            end else begin
              pos_d      = FirstPos;
              mark_d     = '0;
              crc_d      = '0;
              phase_d    = PhPair;
              job_o.two  = 1'b1;
              job_o.act0 = ActCommand;
              job_o.act1 = ActReadPair;
              job_o.cmd  = chosen_d;
            end
          end
        end
        OpPresence: begin
          if (phase_q == PhPresence) begin
            push_o = 1'b1;
            if (!presence_i) begin
              ld_d    = '0;
              phase_d = PhIdle;
            end else begin
              pos_d      = FirstPos;
              mark_d     = '0;
              crc_d      = '0;
              phase_d    = PhPair;
              job_o.two  = 1'b1;
              job_o.act0 = ActCommand;
              job_o.act1 = ActReadPair;
              job_o.cmd  = chosen_q;
            end
          end
        end
        OpPair: begin
          if (phase_q == PhPair) begin
            push_o = 1'b1;
            if (bit_pair_i == 2'b11) begin
              ld_d    = '0;
              phase_d = PhIdle;
            end else begin
              rom_d[bit_idx] = dir;
              if ((bit_pair_i == 2'b00) && !dir) begin
                mark_d = pos_c;
              end
              crc_d      = crc_n;
              pos_d      = pos_c + FirstPos;
              job_o.two  = 1'b1;
              job_o.act0 = ActWriteBit;
              job_o.dir  = dir;
              if (pos_c == LastPos) begin
                ld_d        = crc_ok ? mark_d : '0;
                ldf_d       = crc_ok && (mark_d == '0);
                phase_d     = PhIdle;
                job_o.act1  = ActDone;
                job_o.found = crc_ok;
              end else begin
                job_o.act1 = ActReadPair;
              end
            end
          end
        end
        default: ;
      endcase
    end
    job_o.rom = rom_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      rom_q    <= '0;
      ld_q     <= '0;
      ldf_q    <= 1'b0;
      pos_q    <= FirstPos;
      mark_q   <= '0;
      crc_q    <= '0;
      chosen_q <= SearchCmdRst;
      scmd_q   <= SearchCmdRst;
      acmd_q   <= AlarmCmdRst;
    end else begin
      phase_q  <= phase_d;
      rom_q    <= rom_d;
      ld_q     <= ld_d;
      ldf_q    <= ldf_d;
      pos_q    <= pos_d;
      mark_q   <= mark_d;
      crc_q    <= crc_d;
      chosen_q <= chosen_d;
      if (cfg_we_i && (cfg_idx_i == CfgSearchCmd)) begin
        scmd_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == CfgAlarmCmd)) begin
        acmd_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/owrs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  owrs_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output owrs_pkg::job_t job_o
);
  import owrs_pkg::*;

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_q, wr_d;
  logic [QAw-1:0]   rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/owrs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owrs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  owrs_pkg::job_t              job_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output owrs_pkg::action_e           action_o,
  output logic [owrs_pkg::CmdW-1:0]   command_byte_o,
  output logic                        direction_bit_o,
  output logic                        found_o,
  output logic [owrs_pkg::RomW-1:0]   rom_code_o,
  output logic                        last_o
);
  import owrs_pkg::*;

  logic sel_q, sel_d;
  logic fire;

  assign valid_o         = !empty_i;
  assign action_o        = sel_q ? job_i.act1 : job_i.act0;
  assign command_byte_o  = (action_o == ActCommand) ? job_i.cmd : '0;
  assign direction_bit_o = (action_o == ActWriteBit) && job_i.dir;
  assign found_o         = (action_o == ActDone) && job_i.found;
  assign rom_code_o      = job_i.rom;
  assign last_o          = !job_i.two || sel_q;
  assign fire            = valid_o && ready_i;
  assign pop_o           = fire && last_o;

  always_comb begin
    sel_d = sel_q;
    if (fire) begin
      sel_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/one_wire_rom_search.sv =====
// The first result of a transaction is written into the job queue and leaves from its head.
// Throughput: one input per cycle while the 4-entry job queue is not full; the single
// output port drains one result per cycle while ready; two-result inputs use it twice.
// Reset: rst_ni is asynchronous, active low; clears search state, queue and the
// command registers (0xF0 normal, 0xEC alarm). Input ready is high from reset on.
`timescale 1ns / 1ps
`default_nettype none

`include "one_wire_rom_search_defines.svh"

module one_wire_rom_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // find_first, do_reset, alarm_only, presence, bit_pair[1:0], zero pad
  input  logic [7:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // command_byte[7:0], direction_bit, found, rom_code[63:0], zero pad
  output logic [79:0] m_axis_tdata_o,
  // action[2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import owrs_pkg::*;

  job_t            push_job, head_job;
  logic            push, pop, full, empty;
  action_e         action;
  logic [CmdW-1:0] command_byte;
  logic            direction_bit, found;
  logic [RomW-1:0] rom_code;

  owrs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .valid_i      (s_axis_tvalid_i),
    .ready_o      (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .find_first_i (s_axis_tdata_i[0]),
    .do_reset_i   (s_axis_tdata_i[1]),
    .alarm_only_i (s_axis_tdata_i[2]),
    .presence_i   (s_axis_tdata_i[3]),
    .bit_pair_i   (s_axis_tdata_i[5:4]),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  owrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  owrs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (head_job),
    .empty_i         (empty),
    .pop_o           (pop),
    .valid_o         (m_axis_tvalid_o),
    .ready_i         (m_axis_tready_i),
    .action_o        (action),
    .command_byte_o  (command_byte),
    .direction_bit_o (direction_bit),
    .found_o         (found),
    .rom_code_o      (rom_code),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = action;
  assign m_axis_tdata_o = {6'b0, rom_code, found, direction_bit, command_byte};

  `OWRS_ASSERT_IMPL(done_ends_run, m_axis_tvalid_o && (action == ActDone), m_axis_tlast_o)
  `OWRS_ASSERT_IMPL(cmd_opens_run, m_axis_tvalid_o && (action == ActCommand), !m_axis_tlast_o)
  `OWRS_ASSERT_NEXT(run_held, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o)
  `OWRS_ASSERT_IMPL(queue_no_overflow, push, !full)

endmodule

`default_nettype wire
